/* design/segment_segment_intersect_assert.svh */
// assertion macros for the segment crossing block
`ifndef SEGMENT_SEGMENT_INTERSECT_ASSERT_SVH
`define SEGMENT_SEGMENT_INTERSECT_ASSERT_SVH

// same-cycle implication, off during reset
`define SSI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssi check failed");

// next-cycle implication, off during reset
`define SSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssi check failed");

// next-cycle implication that also holds through reset
`define SSI_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ssi check failed");

`endif

/* design/ssi_pkg.sv */
package ssi_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CRS_W   = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int QUO_W   = DIFF_W + 1;
  localparam int REM_W   = MAG_W + 2;
  localparam int NUM_W   = MAG_W + DIFF_W + 3;
  localparam int PE_W    = 16;
  localparam int PPE_W   = 40;
  localparam int OFF_W   = QUO_W + 1;

  localparam logic [PE_W-1:0]  PE_RESET  = 16'd7;
  localparam logic [PPE_W-1:0] PPE_RESET = 40'd429497;

  localparam logic CFG_REG_POINT_EPS = 1'b0;
  localparam logic CFG_REG_PAR_EPS   = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_a_start_x;
    logic signed [COORD_W-1:0] seg_a_start_y;
    logic signed [COORD_W-1:0] seg_a_end_x;
    logic signed [COORD_W-1:0] seg_a_end_y;
    logic signed [COORD_W-1:0] seg_b_start_x;
    logic signed [COORD_W-1:0] seg_b_start_y;
    logic signed [COORD_W-1:0] seg_b_end_x;
    logic signed [COORD_W-1:0] seg_b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
    logic                      saturated;
  } seg_out_t;

  typedef struct packed {
    logic                      valid;
    logic                      hit;
    logic                      neg;
    logic signed [COORD_W-1:0] base;
  } div_side_t;

endpackage

/* design/ssi_div.sv */
module ssi_div import ssi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  div_side_t        side_in,
  input  logic [NUM_W-1:0] num,
  input  logic [REM_W-1:0] den,
  output div_side_t        side_out,
  output logic [QUO_W-1:0] quo
);

  logic                      vld_r  [QUO_W+1];
  logic                      hit_r  [QUO_W+1];
  logic                      neg_r  [QUO_W+1];
  logic signed [COORD_W-1:0] base_r [QUO_W+1];
  logic [REM_W-1:0]          rem_r  [QUO_W+1];
  logic [REM_W-1:0]          den_r  [QUO_W+1];
  logic [QUO_W-1:0]          low_r  [QUO_W+1];
  logic [QUO_W-1:0]          quo_r  [QUO_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r[0]  <= side_in.hit;
      neg_r[0]  <= side_in.neg;
      base_r[0] <= side_in.base;
      rem_r[0]  <= num[NUM_W-1:QUO_W];
      low_r[0]  <= num[QUO_W-1:0];
      den_r[0]  <= den;
      quo_r[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
      trial = {rem_r[k][REM_W-2:0], low_r[k][QUO_W-1]};
      ge    = (trial >= den_r[k]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hit_r[k+1]  <= hit_r[k];
        neg_r[k+1]  <= neg_r[k];
        base_r[k+1] <= base_r[k];
        den_r[k+1]  <= den_r[k];
        rem_r[k+1]  <= ge ? (trial - den_r[k]) : trial;
        low_r[k+1]  <= {low_r[k][QUO_W-2:0], 1'b0};
        quo_r[k+1]  <= {quo_r[k][QUO_W-2:0], ge};
      end
    end
  end

  assign side_out.valid = vld_r[QUO_W];
  assign side_out.hit   = hit_r[QUO_W];
  assign side_out.neg   = neg_r[QUO_W];
  assign side_out.base  = base_r[QUO_W];
  assign quo            = quo_r[QUO_W];

endmodule

/* design/segment_segment_intersect.sv */
// Segment crossing test on signed Q16.16 endpoints. One item (two segments) enters per
// cycle while the result side is not stalled. Each item passes six stages of differences,
// bounding box and epsilon checks, cross products and offset products, then a 35-stage
// restoring divider (an input register, then 34 stages of one quotient bit each) that
// forms the rounded crossing offset, then the output register. A stall on the result
// side holds the whole pipeline.
// Registers over the APB port: point_epsilon at 0x0, parallel_epsilon at 0x8.
module segment_segment_intersect import ssi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  seg_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output seg_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [PE_W-1:0]  pe_r;
  logic [PPE_W-1:0] ppe_r;
  logic             adv;
  logic             out_valid_r;
  seg_out_t         out_data_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pe_r  <= PE_RESET;
      ppe_r <= PPE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3])
        CFG_REG_POINT_EPS: pe_r  <= cfg_pwdata[PE_W-1:0];
        CFG_REG_PAR_EPS:   ppe_r <= cfg_pwdata[PPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3])
      CFG_REG_POINT_EPS: cfg_prdata = {{(64-PE_W){1'b0}}, pe_r};
      CFG_REG_PAR_EPS:   cfg_prdata = {{(64-PPE_W){1'b0}}, ppe_r};
      default:           cfg_prdata = '0;
    endcase
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage 1: differences, degenerate and box rejects
  logic signed [DIFF_W-1:0] rax, ray, rbx, rby, dx, dy;
  logic [DIFF_W-1:0]        arax, aray, arbx, arby;
  logic signed [COORD_W-1:0] amaxx, aminx, amaxy, aminy, bmaxx, bminx, bmaxy, bminy;
  logic                     rej1;

  always_comb begin
    rax = $signed({in_data.seg_a_end_x[COORD_W-1], in_data.seg_a_end_x})
        - $signed({in_data.seg_a_start_x[COORD_W-1], in_data.seg_a_start_x});
    ray = $signed({in_data.seg_a_end_y[COORD_W-1], in_data.seg_a_end_y})
        - $signed({in_data.seg_a_start_y[COORD_W-1], in_data.seg_a_start_y});
    rbx = $signed({in_data.seg_b_end_x[COORD_W-1], in_data.seg_b_end_x})
        - $signed({in_data.seg_b_start_x[COORD_W-1], in_data.seg_b_start_x});
    rby = $signed({in_data.seg_b_end_y[COORD_W-1], in_data.seg_b_end_y})
        - $signed({in_data.seg_b_start_y[COORD_W-1], in_data.seg_b_start_y});
    dx  = $signed({in_data.seg_b_start_x[COORD_W-1], in_data.seg_b_start_x})
        - $signed({in_data.seg_a_start_x[COORD_W-1], in_data.seg_a_start_x});
    dy  = $signed({in_data.seg_b_start_y[COORD_W-1], in_data.seg_b_start_y})
        - $signed({in_data.seg_a_start_y[COORD_W-1], in_data.seg_a_start_y});
    arax = rax[DIFF_W-1] ? DIFF_W'(-rax) : DIFF_W'(rax);
    aray = ray[DIFF_W-1] ? DIFF_W'(-ray) : DIFF_W'(ray);
    arbx = rbx[DIFF_W-1] ? DIFF_W'(-rbx) : DIFF_W'(rbx);
    arby = rby[DIFF_W-1] ? DIFF_W'(-rby) : DIFF_W'(rby);
    amaxx = (in_data.seg_a_start_x > in_data.seg_a_end_x) ? in_data.seg_a_start_x
                                                          : in_data.seg_a_end_x;
    aminx = (in_data.seg_a_start_x < in_data.seg_a_end_x) ? in_data.seg_a_start_x
                                                          : in_data.seg_a_end_x;
    amaxy = (in_data.seg_a_start_y > in_data.seg_a_end_y) ? in_data.seg_a_start_y
                                                          : in_data.seg_a_end_y;
    aminy = (in_data.seg_a_start_y < in_data.seg_a_end_y) ? in_data.seg_a_start_y
                                                          : in_data.seg_a_end_y;
    bmaxx = (in_data.seg_b_start_x > in_data.seg_b_end_x) ? in_data.seg_b_start_x
                                                          : in_data.seg_b_end_x;
    bminx = (in_data.seg_b_start_x < in_data.seg_b_end_x) ? in_data.seg_b_start_x
                                                          : in_data.seg_b_end_x;
    bmaxy = (in_data.seg_b_start_y > in_data.seg_b_end_y) ? in_data.seg_b_start_y
                                                          : in_data.seg_b_end_y;
    bminy = (in_data.seg_b_start_y < in_data.seg_b_end_y) ? in_data.seg_b_start_y
                                                          : in_data.seg_b_end_y;
    rej1 = (arax < DIFF_W'(pe_r) && aray < DIFF_W'(pe_r))
        || (arbx < DIFF_W'(pe_r) && arby < DIFF_W'(pe_r))
        || (amaxx < bminx) || (aminx > bmaxx)
        || (amaxy < bminy) || (aminy > bmaxy);
  end

  logic                      v1_r, rej1_r;
  logic signed [DIFF_W-1:0]  rax1_r, ray1_r, rbx1_r, rby1_r, dx1_r, dy1_r;
  logic signed [COORD_W-1:0] bx1_r, by1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rej1_r <= rej1;
      rax1_r <= rax;
      ray1_r <= ray;
      rbx1_r <= rbx;
      rby1_r <= rby;
      dx1_r  <= dx;
      dy1_r  <= dy;
      bx1_r  <= in_data.seg_b_start_x;
      by1_r  <= in_data.seg_b_start_y;
    end
  end

  // stage 2: cross products
  logic                      v2_r, rej2_r;
  logic signed [PROD_W-1:0]  p_bay_r, p_bya_r, p_dyb_r, p_dxb_r, p_dxa_r, p_dya_r;
  logic signed [DIFF_W-1:0]  rbx2_r, rby2_r;
  logic signed [COORD_W-1:0] bx2_r, by2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rej2_r  <= rej1_r;
      p_bay_r <= rbx1_r * ray1_r;
      p_bya_r <= rby1_r * rax1_r;
      p_dyb_r <= dy1_r * rbx1_r;
      p_dxb_r <= dx1_r * rby1_r;
      p_dxa_r <= dx1_r * ray1_r;
      p_dya_r <= dy1_r * rax1_r;
      rbx2_r  <= rbx1_r;
      rby2_r  <= rby1_r;
      bx2_r   <= bx1_r;
      by2_r   <= by1_r;
    end
  end

  // stage 3: denominator and numerators
  logic                      v3_r, rej3_r;
  logic signed [CRS_W-1:0]   den3_r, num13_r, num23_r;
  logic signed [DIFF_W-1:0]  rbx3_r, rby3_r;
  logic signed [COORD_W-1:0] bx3_r, by3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rej3_r  <= rej2_r;
      den3_r  <= $signed({p_bay_r[PROD_W-1], p_bay_r}) - $signed({p_bya_r[PROD_W-1], p_bya_r});
      num13_r <= $signed({p_dyb_r[PROD_W-1], p_dyb_r}) - $signed({p_dxb_r[PROD_W-1], p_dxb_r});
      num23_r <= $signed({p_dxa_r[PROD_W-1], p_dxa_r}) - $signed({p_dya_r[PROD_W-1], p_dya_r});
      rbx3_r  <= rbx2_r;
      rby3_r  <= rby2_r;
      bx3_r   <= bx2_r;
      by3_r   <= by2_r;
    end
  end

  // stage 4: magnitudes and signs
  logic [CRS_W-1:0]          den_abs, num1_abs, num2_abs;
  logic [DIFF_W-1:0]         rbx_abs, rby_abs;
  logic                      v4_r, rej4_r;
  logic [MAG_W-1:0]          den4_r, num14_r, num24_r;
  logic                      dneg4_r, n1neg4_r, n2neg4_r, bxneg4_r, byneg4_r;
  logic [DIFF_W-1:0]         rbx4_r, rby4_r;
  logic signed [COORD_W-1:0] bx4_r, by4_r;

  always_comb begin
    den_abs  = den3_r[CRS_W-1]  ? CRS_W'(-den3_r)  : CRS_W'(den3_r);
    num1_abs = num13_r[CRS_W-1] ? CRS_W'(-num13_r) : CRS_W'(num13_r);
    num2_abs = num23_r[CRS_W-1] ? CRS_W'(-num23_r) : CRS_W'(num23_r);
    rbx_abs  = rbx3_r[DIFF_W-1] ? DIFF_W'(-rbx3_r) : DIFF_W'(rbx3_r);
    rby_abs  = rby3_r[DIFF_W-1] ? DIFF_W'(-rby3_r) : DIFF_W'(rby3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rej4_r   <= rej3_r;
      den4_r   <= den_abs[MAG_W-1:0];
      num14_r  <= num1_abs[MAG_W-1:0];
      num24_r  <= num2_abs[MAG_W-1:0];
      dneg4_r  <= den3_r[CRS_W-1];
      n1neg4_r <= num13_r[CRS_W-1];
      n2neg4_r <= num23_r[CRS_W-1];
      bxneg4_r <= rbx3_r[DIFF_W-1];
      byneg4_r <= rby3_r[DIFF_W-1];
      rbx4_r   <= rbx_abs;
      rby4_r   <= rby_abs;
      bx4_r    <= bx3_r;
      by4_r    <= by3_r;
    end
  end

  // stage 5: parallel and parameter tests, offset partial products
  logic                      hit5, ok1, ok2;
  logic                      v5_r, hit5_r, negx5_r, negy5_r;
  logic [PROD_W-1:0]         pxl_r, pxh_r, pyl_r, pyh_r;
  logic [MAG_W-1:0]          den5_r;
  logic signed [COORD_W-1:0] bx5_r, by5_r;

  always_comb begin
    ok1  = (num14_r == '0) || (n1neg4_r == dneg4_r && num14_r <= den4_r);
    ok2  = (num24_r == '0) || (n2neg4_r == !dneg4_r && num24_r <= den4_r);
    hit5 = !rej4_r && (den4_r != '0) && (den4_r >= MAG_W'(ppe_r)) && ok1 && ok2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit5_r  <= hit5;
      negx5_r <= bxneg4_r ^ n2neg4_r ^ !dneg4_r;
      negy5_r <= byneg4_r ^ n2neg4_r ^ !dneg4_r;
      pxl_r   <= rbx4_r * num24_r[DIFF_W-1:0];
      pxh_r   <= rbx4_r * num24_r[MAG_W-1:DIFF_W];
      pyl_r   <= rby4_r * num24_r[DIFF_W-1:0];
      pyh_r   <= rby4_r * num24_r[MAG_W-1:DIFF_W];
      den5_r  <= den4_r;
      bx5_r   <= bx4_r;
      by5_r   <= by4_r;
    end
  end

  // stage 6: rounded dividends
  logic [NUM_W-1:0] prod_x, prod_y;
  logic             v6_r, hit6_r, negx6_r, negy6_r;
  logic [NUM_W-1:0] nx6_r, ny6_r;
  logic [REM_W-1:0] d6_r;
  logic signed [COORD_W-1:0] bx6_r, by6_r;

  always_comb begin
    prod_x = (NUM_W'(pxh_r) << DIFF_W) + NUM_W'(pxl_r);
    prod_y = (NUM_W'(pyh_r) << DIFF_W) + NUM_W'(pyl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit6_r  <= hit5_r;
      negx6_r <= negx5_r;
      negy6_r <= negy5_r;
      nx6_r   <= (prod_x << 1) + NUM_W'(den5_r);
      ny6_r   <= (prod_y << 1) + NUM_W'(den5_r);
      d6_r    <= REM_W'({den5_r, 1'b0});
      bx6_r   <= bx5_r;
      by6_r   <= by5_r;
    end
  end

  div_side_t        sx_in, sy_in, sx_out, sy_out;
  logic [QUO_W-1:0] qx, qy;

  assign sx_in = '{valid: v6_r, hit: hit6_r, neg: negx6_r, base: bx6_r};
  assign sy_in = '{valid: v6_r, hit: hit6_r, neg: negy6_r, base: by6_r};

  ssi_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .side_in  (sx_in),
    .num      (nx6_r),
    .den      (d6_r),
    .side_out (sx_out),
    .quo      (qx)
  );

  ssi_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .side_in  (sy_in),
    .num      (ny6_r),
    .den      (d6_r),
    .side_out (sy_out),
    .quo      (qy)
  );

  // final add and clip
  logic signed [OFF_W-1:0] offx, offy, sumx, sumy;
  logic signed [OFF_W-1:0] cmax, cmin;
  logic                    satx, saty;
  logic signed [COORD_W-1:0] cx, cy;

  always_comb begin
    cmax = OFF_W'({1'b0, {(COORD_W-1){1'b1}}});
    cmin = -cmax - OFF_W'(1);
    offx = sx_out.neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    offy = sy_out.neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    sumx = OFF_W'(sx_out.base) + offx;
    sumy = OFF_W'(sy_out.base) + offy;
    satx = (sumx > cmax) || (sumx < cmin);
    saty = (sumy > cmax) || (sumy < cmin);
    cx   = (sumx > cmax) ? cmax[COORD_W-1:0] : (sumx < cmin) ? cmin[COORD_W-1:0]
                                                              : sumx[COORD_W-1:0];
    cy   = (sumy > cmax) ? cmax[COORD_W-1:0] : (sumy < cmin) ? cmin[COORD_W-1:0]
                                                              : sumy[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sx_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.hit       <= sx_out.hit;
      out_data_r.cross_x   <= sx_out.hit ? cx : '0;
      out_data_r.cross_y   <= sx_out.hit ? cy : '0;
      out_data_r.saturated <= sx_out.hit && (satx || saty);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/ssi_chk.sv */
`include "segment_segment_intersect_assert.svh"

module ssi_chk import ssi_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input seg_out_t out_data
);

  logic miss_clean;

  assign miss_clean = (out_data.cross_x == '0) && (out_data.cross_y == '0)
                   && !out_data.saturated;

  `SSI_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_valid)
  `SSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SSI_ASSERT_SAME(a_miss_zero, out_valid && !out_data.hit, miss_clean)

endmodule

bind segment_segment_intersect ssi_chk u_ssi_chk (.*);
